/* rtl/mcg_pkg.sv */
// ----------------------------------------------------------------------------
// mcg_pkg
// Types and constants shared by the midpoint circle generator.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int unsigned CX_W  = 15;  // centre coordinate width
  localparam int unsigned RAD_W = 12;  // radius width
  localparam int unsigned OFS_W = 13;  // offset width, holds radius + 1
  localparam int unsigned ERR_W = 16;  // error term width
  localparam int unsigned OUT_W = 16;  // result coordinate width
  localparam int unsigned IDX_W = 3;   // index of a result within a step

  localparam logic [IDX_W-1:0] LAST_IDX_POINT = 3'd7;  // eight octant points
  localparam logic [IDX_W-1:0] LAST_IDX_SPAN  = 3'd3;  // four spans

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_e;

  // One step's worth of work handed to the emitter
  typedef struct packed {
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic [RAD_W-1:0]       r;
    logic [OFS_W-1:0]       t;
    logic                   fill;
    logic                   done;
  } job_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_left;
    logic signed [OUT_W-1:0] x_right;
    logic signed [OUT_W-1:0] y_row;
    logic                    last;
    logic                    done_res;
  } res_t;

endpackage

/* rtl/mcg_if.sv */
// ----------------------------------------------------------------------------
// mcg_if
// Request and result channels of the midpoint circle generator.
// ----------------------------------------------------------------------------
interface mcg_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [14:0]        center_x;
  logic signed [14:0]        center_y;
  logic [11:0]               radius;
  logic                      filled;

  modport source (output valid, req_type, center_x, center_y, radius, filled,
                  input ready);
  modport sink   (input valid, req_type, center_x, center_y, radius, filled,
                  output ready);
endinterface

interface mcg_res_if;
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        x_left;
  logic signed [15:0]        x_right;
  logic signed [15:0]        y_row;
  logic                      last;
  logic                      done_res;

  modport source (output valid, x_left, x_right, y_row, last, done_res,
                  input ready);
  modport sink   (input valid, x_left, x_right, y_row, last, done_res,
                  output ready);
endinterface

/* rtl/mcg_state.sv */
// ----------------------------------------------------------------------------
// mcg_state
// Circle state: loads on start, advances offset/error/radius on each step
// and hands the pre-update values to the emitter as a job.
// ----------------------------------------------------------------------------
module mcg_state #(
  parameter int unsigned RADIUS_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        req_type_i,
  input  logic signed [14:0]          center_x_i,
  input  logic signed [14:0]          center_y_i,
  input  logic [11:0]                 radius_i,
  input  logic                        filled_i,
  output logic                        job_valid_o,
  output mcg_pkg::job_t               job_o
);
  import mcg_pkg::*;

  localparam logic [RAD_W-1:0] RadMask = (RADIUS_BITS >= RAD_W) ? {RAD_W{1'b1}} :
                                         RAD_W'((1 << RADIUS_BITS) - 1);

  logic signed [CX_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0]       r_q, r_d;
  logic [OFS_W-1:0]       t_q, t1;
  logic [ERR_W-1:0]       err_q, err_d, err1, err2;
  logic                   fill_q, active_q, active_d;
  logic                   is_step, has_work, dec_r, done;
  logic signed [RAD_W+1:0] rn;

  assign is_step  = (req_type_i == REQ_STEP);
  assign has_work = active_q && ({1'b0, r_q} >= t_q);

  always_comb begin
    t1    = t_q + 1'b1;
    err1  = err_q + 16'd1 + {2'b00, t1, 1'b0};
    // 2(err - r) + 1 > 0 is err >= r
    dec_r = $signed({err1[ERR_W-1], err1}) >= $signed({5'b0, r_q});
    rn    = $signed({2'b00, r_q}) - $signed({13'b0, dec_r});
    // err + 1 - 2(r - 1)
    err2  = err1 + 16'd3 - {3'b000, r_q, 1'b0};
    done  = rn < $signed({1'b0, t1});
    err_d = dec_r ? err2 : err1;
    r_d   = rn[RAD_W+1] ? '0 : rn[RAD_W-1:0];
    active_d = !done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      r_q      <= '0;
      t_q      <= '0;
      err_q    <= '0;
      fill_q   <= 1'b0;
      active_q <= 1'b0;
    end else if (accept_i) begin
      if (!is_step) begin
        cx_q     <= center_x_i;
        cy_q     <= center_y_i;
        r_q      <= radius_i & RadMask;
        t_q      <= '0;
        err_q    <= '0;
        fill_q   <= filled_i;
        active_q <= 1'b1;
      end else if (has_work) begin
        r_q      <= r_d;
        t_q      <= t1;
        err_q    <= err_d;
        active_q <= active_d;
      end else begin
        active_q <= 1'b0;
      end
    end
  end

  assign job_valid_o = accept_i && is_step && has_work;

  always_comb begin
    job_o.cx   = cx_q;
    job_o.cy   = cy_q;
    job_o.r    = r_q;
    job_o.t    = t_q;
    job_o.fill = fill_q;
    job_o.done = done;
  end

endmodule

/* rtl/mcg_emit.sv */
// ----------------------------------------------------------------------------
// mcg_emit
// Holds one step's job and walks its points or spans into the result
// register, one beat per cycle unless the result register is stalled.
// ----------------------------------------------------------------------------
module mcg_emit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  mcg_pkg::job_t job_i,
  output logic          free_o,
  mcg_res_if.source     res_o
);
  import mcg_pkg::*;

  localparam logic [OUT_W-1:0] CoordMask = (COORD_BITS >= OUT_W) ? {OUT_W{1'b1}} :
                                           OUT_W'((1 << COORD_BITS) - 1);

  job_t             job_q;
  logic             job_valid_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] last_idx;
  logic             out_valid_q;
  res_t             res_q, res_d;
  logic             load, issue_last;
  logic             use_r, xneg, yneg;
  logic [OFS_W-1:0] mag_x, mag_y;
  logic signed [OUT_W:0] cx_e, cy_e, xp, xm, yp, ym, xl, xr, yr;

  assign last_idx   = job_q.fill ? LAST_IDX_SPAN : LAST_IDX_POINT;
  assign load       = job_valid_q && (!out_valid_q || res_o.ready);
  assign issue_last = load && (idx_q == last_idx);
  assign free_o     = !job_valid_q || issue_last;

  // x uses r and y uses t, or the other way round; signs per beat
  always_comb begin
    use_r = 1'b0;
    xneg  = 1'b0;
    yneg  = 1'b0;
    if (job_q.fill) begin
      use_r = !idx_q[1];
      yneg  = idx_q[0];
    end else begin
      unique case (idx_q)
        3'd0:    begin use_r = 1'b1; xneg = 1'b0; yneg = 1'b0; end
        3'd1:    begin use_r = 1'b0; xneg = 1'b0; yneg = 1'b0; end
        3'd2:    begin use_r = 1'b0; xneg = 1'b1; yneg = 1'b0; end
        3'd3:    begin use_r = 1'b1; xneg = 1'b1; yneg = 1'b0; end
        3'd4:    begin use_r = 1'b1; xneg = 1'b1; yneg = 1'b1; end
        3'd5:    begin use_r = 1'b0; xneg = 1'b1; yneg = 1'b1; end
        3'd6:    begin use_r = 1'b0; xneg = 1'b0; yneg = 1'b1; end
        default: begin use_r = 1'b1; xneg = 1'b0; yneg = 1'b1; end
      endcase
    end
  end

  always_comb begin
    mag_x = use_r ? {1'b0, job_q.r} : job_q.t;
    mag_y = use_r ? job_q.t : {1'b0, job_q.r};
    cx_e  = {{2{job_q.cx[CX_W-1]}}, job_q.cx};
    cy_e  = {{2{job_q.cy[CX_W-1]}}, job_q.cy};
    xp    = cx_e + $signed({4'b0, mag_x});
    xm    = cx_e - $signed({4'b0, mag_x});
    yp    = cy_e + $signed({4'b0, mag_y});
    ym    = cy_e - $signed({4'b0, mag_y});
    if (job_q.fill) begin
      xl = xm;
      xr = xp;
    end else begin
      xl = xneg ? xm : xp;
      xr = xl;
    end
    yr = yneg ? ym : yp;
    res_d.x_left   = xl[OUT_W-1:0] & CoordMask;
    res_d.x_right  = xr[OUT_W-1:0] & CoordMask;
    res_d.y_row    = yr[OUT_W-1:0] & CoordMask;
    res_d.last     = (idx_q == last_idx);
    res_d.done_res = job_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_valid_i) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (load) begin
        idx_q <= idx_q + 1'b1;
        if (issue_last) job_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i) job_q <= job_i;
    if (load) res_q <= res_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.x_left   = res_q.x_left;
  assign res_o.x_right  = res_q.x_right;
  assign res_o.y_row    = res_q.y_row;
  assign res_o.last     = res_q.last;
  assign res_o.done_res = res_q.done_res;

endmodule

/* rtl/midpoint_circle_generator.sv */
// A step beat loads the job register; its results then go out through the
// result register: eight in outline mode, four in filled mode, one result per
// cycle while the receiver does not stall. Start beats and empty steps give none.
// The step job register frees on the step's last result, taking the next beat then.
// Reset (async, active low) clears the circle state and empties both registers.
// ----------------------------------------------------------------------------
// midpoint_circle_generator
// Midpoint circle rasterizer: outline points or filled spans, step by step.
// ----------------------------------------------------------------------------
module midpoint_circle_generator #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned RADIUS_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcg_req_if.sink   req_i,
  mcg_res_if.source res_o
);
  import mcg_pkg::*;

  logic accept;
  logic job_valid;
  job_t job;
  logic free;

  assign req_i.ready = free;
  assign accept      = req_i.valid && free;

  mcg_state #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_i.req_type),
    .center_x_i  (req_i.center_x),
    .center_y_i  (req_i.center_y),
    .radius_i    (req_i.radius),
    .filled_i    (req_i.filled),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  mcg_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .free_o      (free),
    .res_o       (res_o)
  );

endmodule

/* rtl/mcg_checker.sv */
// ----------------------------------------------------------------------------
// mcg_checker
// Port-level checks on the circle generator's result channel.
// ----------------------------------------------------------------------------
module mcg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] x_left_i,
  input logic [15:0] x_right_i,
  input logic [15:0] y_row_i,
  input logic        last_i,
  input logic        done_res_i
);

  a_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(x_left_i) && $stable(x_right_i) &&
      $stable(y_row_i) && $stable(last_i) && $stable(done_res_i))
    else $error("stalled result changed");

  // a stalled mid-step beat means the step is still busy
  a_busy_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && !last_i |-> !in_ready_i)
    else $error("request taken while a step is still emitting");

  // the rest of a step follows without a gap
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("gap inside a step's results");

endmodule

bind midpoint_circle_generator mcg_checker u_mcg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .x_left_i    (res_o.x_left),
  .x_right_i   (res_o.x_right),
  .y_row_i     (res_o.y_row),
  .last_i      (res_o.last),
  .done_res_i  (res_o.done_res)
);

/* test/midpoint_circle_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_generator_tb
// Self-checking bench for the midpoint circle generator. A short directed
// table covers reset, radius zero, coordinate and radius extremes and restart
// while running; random circles follow under four idle/stall phases. Every
// result beat is checked in order against the in-bench midpoint predictor or a typed row.
// ----------------------------------------------------------------------------
module midpoint_circle_generator_tb;
  import mcg_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RST_CYCLES      = 6;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int NUM_PHASES      = 4;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int MAX_PRINTS      = 100;
  localparam int NUM_ROWS        = 25;

  typedef enum logic [1:0] {
    CHK_MODEL,   // expectation from the predictor
    CHK_NONE,    // typed: no result beats
    CHK_CENTRE   // typed: n beats all at the centre, closing the circle
  } row_chk_e;

  typedef struct packed {
    req_e                   kind;
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic [RAD_W-1:0]       rad;
    logic                   fill;
  } circle_req_t;

  typedef struct packed {
    circle_req_t             req;
    row_chk_e                chk;
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
    logic [3:0]              n;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mcg_req_if req_bus ();
  mcg_res_if res_bus ();

  midpoint_circle_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Directed table
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_NONE,       0,      0, 0},
    '{'{REQ_START,      0,      0,    0, 1'b0}, CHK_NONE,       0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_CENTRE,     0,      0, 8},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_NONE,       0,      0, 0},
    '{'{REQ_START,  16383, -16384,    0, 1'b1}, CHK_NONE,       0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_CENTRE, 16383, -16384, 4},
    '{'{REQ_START, -16384,  16383, 4095, 1'b0}, CHK_NONE,       0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_START,  16383,  16383, 4095, 1'b1}, CHK_NONE,       0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_START, -16384, -16384,    1, 1'b0}, CHK_NONE,       0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_START,    100,    -50,    5, 1'b1}, CHK_NONE,       0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_START,     -1,      1,    3, 1'b0}, CHK_NONE,       0,      0, 0},
    // step payload is don't-care: drive it all ones
    '{'{REQ_STEP,      -1,     -1, 4095, 1'b1}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0},
    '{'{REQ_STEP,       0,      0,    0, 1'b0}, CHK_MODEL,      0,      0, 0}
  };

  int send_idle_tab  [NUM_PHASES] = '{0, 88, 0, 12};
  int recv_stall_tab [NUM_PHASES] = '{0, 0, 88, 12};
  int send_idle_pct;
  int recv_stall_pct;

  // Predictor state
  logic signed [CX_W-1:0]  pred_cx;
  logic signed [CX_W-1:0]  pred_cy;
  logic [RAD_W-1:0]        pred_rad;
  logic [OFS_W-1:0]        pred_ofs;
  logic signed [ERR_W-1:0] pred_err;
  logic                    pred_fill;
  logic                    pred_active;

  res_t step_res [8];
  int   step_cnt;
  res_t expected_beats [$];

  int mismatches;
  int checked_beats;
  int items_sent;
  int starts_sent;
  int circles_done;
  int cycle_count;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_span(input int xl, input int xr, input int y);
    step_res[step_cnt] = '{x_left: OUT_W'(xl), x_right: OUT_W'(xr), y_row: OUT_W'(y),
                           last: 1'b0, done_res: 1'b0};
    step_cnt++;
  endtask

  // One request through the midpoint predictor; beats land in step_res
  task automatic circle_step(input circle_req_t it);
    int   r;
    int   t;
    logic fin;
    step_cnt = 0;
    if (it.kind == REQ_START) begin
      pred_cx     = it.cx;
      pred_cy     = it.cy;
      pred_rad    = it.rad;
      pred_fill   = it.fill;
      pred_ofs    = '0;
      pred_err    = '0;
      pred_active = 1'b1;
      return;
    end
    if (!pred_active || int'(pred_rad) < int'(pred_ofs)) begin
      pred_active = 1'b0;
      return;
    end
    r = int'(pred_rad);
    t = int'(pred_ofs);
    if (!pred_fill) begin
      add_span(pred_cx + r, pred_cx + r, pred_cy + t);
      add_span(pred_cx + t, pred_cx + t, pred_cy + r);
      add_span(pred_cx - t, pred_cx - t, pred_cy + r);
      add_span(pred_cx - r, pred_cx - r, pred_cy + t);
      add_span(pred_cx - r, pred_cx - r, pred_cy - t);
      add_span(pred_cx - t, pred_cx - t, pred_cy - r);
      add_span(pred_cx + t, pred_cx + t, pred_cy - r);
      add_span(pred_cx + r, pred_cx + r, pred_cy - t);
    end else begin
      add_span(pred_cx - r, pred_cx + r, pred_cy + t);
      add_span(pred_cx - r, pred_cx + r, pred_cy - t);
      add_span(pred_cx - t, pred_cx + t, pred_cy + r);
      add_span(pred_cx - t, pred_cx + t, pred_cy - r);
    end
    t = t + 1;
    pred_err = ERR_W'(int'(pred_err) + 1 + 2 * t);
    if (2 * (int'(pred_err) - r) + 1 > 0) begin
      r = r - 1;
      pred_err = ERR_W'(int'(pred_err) + 1 - 2 * r);
    end
    pred_ofs = OFS_W'(t);
    fin = (r < t);
    // radius may dip to -1 on the final step; only active matters then
    pred_rad = (r < 0) ? '0 : RAD_W'(r);
    if (fin) pred_active = 1'b0;
    for (int k = 0; k < step_cnt; k++) step_res[k].done_res = fin;
    step_res[step_cnt-1].last = 1'b1;
  endtask

  function automatic circle_req_t rand_req();
    circle_req_t it;
    it.kind = req_e'($urandom_range(0, 1));
    it.cx   = CX_W'($urandom);
    it.cy   = CX_W'($urandom);
    it.rad  = RAD_W'($urandom);
    it.fill = 1'($urandom);
    return it;
  endfunction

  task automatic drive_req(input circle_req_t it);
    req_bus.req_type <= it.kind;
    req_bus.center_x <= it.cx;
    req_bus.center_y <= it.cy;
    req_bus.radius   <= it.rad;
    req_bus.filled   <= it.fill;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic send_req(input circle_req_t it, input row_chk_e chk,
                          input logic signed [OUT_W-1:0] ex,
                          input logic signed [OUT_W-1:0] ey, input int n);
    res_t beat;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      drive_req(rand_req());
      @(negedge clk_i);
    end
    req_bus.valid <= 1'b1;
    drive_req(it);
    do @(posedge clk_i); while (!req_bus.ready);
    circle_step(it);
    items_sent++;
    if (it.kind == REQ_START) starts_sent++;
    if (chk == CHK_MODEL) begin
      for (int k = 0; k < step_cnt; k++) expected_beats = {expected_beats, step_res[k]};
    end else if (chk == CHK_CENTRE) begin
      for (int k = 0; k < n; k++) begin
        beat = '{x_left: ex, x_right: ex, y_row: ey, last: (k == n - 1), done_res: 1'b1};
        expected_beats = {expected_beats, beat};
      end
    end
    @(negedge clk_i);
  endtask

  // Mostly whole circles with random content, some cut short, some noise
  task automatic run_random_phase(input int items);
    int          useful;
    int          sel;
    int          nsteps;
    circle_req_t it;
    useful = 0;
    while (useful < items) begin
      if ($urandom_range(0, 99) < 85) begin
        it      = rand_req();
        it.kind = REQ_START;
        sel     = $urandom_range(0, 99);
        if (sel < 88) it.rad = RAD_W'($urandom_range(0, 15));
        else if (sel < 96) it.rad = RAD_W'($urandom_range(16, 48));
        send_req(it, CHK_MODEL, '0, '0, 0);
        useful++;
        if (it.rad > 48) nsteps = $urandom_range(1, 4);
        else nsteps = (int'(it.rad) * 707) / 1000 + 1 + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) nsteps = $urandom_range(0, nsteps);
        repeat (nsteps) begin
          it      = rand_req();
          it.kind = REQ_STEP;
          send_req(it, CHK_MODEL, '0, '0, 0);
          if (step_cnt != 0) useful++;
        end
      end else begin
        it = rand_req();
        send_req(it, CHK_MODEL, '0, '0, 0);
        if (it.kind == REQ_START || step_cnt != 0) useful++;
      end
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got = '{x_left: res_bus.x_left, x_right: res_bus.x_right, y_row: res_bus.y_row,
              last: res_bus.last, done_res: res_bus.done_res};
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d..%0d y=%0d last=%0b done=%0b",
                                  got.x_left, got.x_right, got.y_row, got.last,
                                  got.done_res));
      end else begin
        want = expected_beats.pop_front();
        checked_beats++;
        if (want.last && want.done_res) circles_done++;
        if (got.x_left !== want.x_left || got.x_right !== want.x_right ||
            got.y_row !== want.y_row || got.last !== want.last ||
            got.done_res !== want.done_res)
          report_mismatch($sformatf(
            "beat %0d got x=%0d..%0d y=%0d l=%0b d=%0b exp x=%0d..%0d y=%0d l=%0b d=%0b",
            checked_beats, got.x_left, got.x_right, got.y_row, got.last, got.done_res,
            want.x_left, want.x_right, want.y_row, want.last, want.done_res));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats outstanding", cycle_count,
               expected_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_START;
    req_bus.center_x = '0;
    req_bus.center_y = '0;
    req_bus.radius   = '0;
    req_bus.filled   = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatches       = 0;
    checked_beats    = 0;
    items_sent       = 0;
    starts_sent      = 0;
    circles_done     = 0;
    cycle_count      = 0;
    pred_cx          = '0;
    pred_cy          = '0;
    pred_rad         = '0;
    pred_ofs         = '0;
    pred_err         = '0;
    pred_fill        = 1'b0;
    pred_active      = 1'b0;
    step_cnt         = 0;

    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++)
      send_req(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].ex, dir_rows[i].ey,
               int'(dir_rows[i].n));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // hold off until the block has drained before each phase
      req_bus.valid <= 1'b0;
      do @(negedge clk_i); while (expected_beats.size() != 0);
      send_idle_pct  = send_idle_tab[ph];
      recv_stall_pct = recv_stall_tab[ph];
      run_random_phase(ITEMS_PER_PHASE);
    end

    req_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d request beats (%0d starts); checked %0d result beats, %0d circles closed",
             items_sent, starts_sent, checked_beats, circles_done);
    $display("Ran open, sender-idle, receiver-stall and mixed phases; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
